// File: hdl/srlp_pkg.sv
// Package: shared constants, payload structs and cell control type for the sorted record list.
package srlp_pkg;

   localparam int CAPACITY_DEFAULT = 32;
   localparam int LIMIT_WIDTH      = 24;
   localparam int LEN_WIDTH        = 6;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_READOUT = 1'b1;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_ENTRY = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   typedef struct packed {
      logic        operation;
      logic [63:0] first_stamp;
      logic [63:0] last_stamp;
      logic [31:0] data_offset;
      logic [15:0] point_count;
      logic [15:0] data_bytes;
      logic        compressed;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] entry_start_time;
      logic [63:0] entry_end_time;
      logic [31:0] entry_offset;
      logic [15:0] entry_point_count;
      logic [15:0] entry_length;
      logic        entry_compressed;
      logic [5:0]  list_length;
      logic        overflow;
      logic        last;
   } rsp_type;

   // One stored record.
   typedef struct packed {
      logic [63:0] first_stamp;
      logic [63:0] last_stamp;
      logic [31:0] data_offset;
      logic [15:0] point_count;
      logic [15:0] data_bytes;
      logic        compressed;
   } rec_type;

   // Control broadcast to every cell.
   typedef struct packed {
      logic insert;   // cells at or past the insert point shift right, key cell loads
      logic shift;    // whole chain shifts one toward the head (read-out)
   } cell_ctrl_type;

endpackage

// File: hdl/srlp_cell.sv
// Module: one storage cell of the sorted chain.
module srlp_cell (
   input  logic                    clock,
   input  srlp_pkg::cell_ctrl_type ctrl,
   input  srlp_pkg::rec_type       new_rec,
   input  srlp_pkg::rec_type       left_rec,
   input  logic                    left_greater,
   input  logic                    vacant,
   input  srlp_pkg::rec_type       right_rec,
   output srlp_pkg::rec_type       rec,
   output logic                    greater
);

   srlp_pkg::rec_type rec_ff, rec_in;

   // Stored start time strictly later than the new key: insert goes in front.
   assign greater = rec_ff.first_stamp > new_rec.first_stamp;
   assign rec     = rec_ff;

   always_comb begin
      rec_in = rec_ff;
      if (ctrl.shift) begin
         rec_in = right_rec;
      end else if (ctrl.insert && (greater || vacant)) begin
         rec_in = left_greater ? left_rec : new_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

// File: hdl/sorted_record_list_with_limit_prune_top.sv
// Module: top level of the sorted record list with point-limit prune.
//
//   channel  ports                          direction  handshake
//   request  start, busy, req_item          in         taken when start && !busy
//   result   rsp_valid, rsp_item            out        one-cycle strobe, no back-pressure
//   config   csr_valid, csr_ready, csr_data in         written when csr_valid && csr_ready
//
// An insert does its compare-and-shift in the cell chain in ST_INSERT. With a zero limit
// the acknowledge follows in the next cycle. Otherwise a prune walk sums points from the
// head until the limit is met; ST_CUT then advances past entries tied with the bound
// and cuts the count before the acknowledge. A walk that ends the list acknowledges too.
// A read-out shifts the chain toward the head one entry per cycle, emitting one
// item each cycle; an empty read-out or a dropped insert answers in the next cycle.
// Reset clears the entry count and control; cell contents stay undefined until
// written. The receiver cannot stall; busy holds off new items while one is at work.
module sorted_record_list_with_limit_prune_top #(
   parameter int CAPACITY = srlp_pkg::CAPACITY_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  srlp_pkg::req_type                     req_item,
   output logic                                  rsp_valid,
   output srlp_pkg::rsp_type                     rsp_item,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [srlp_pkg::LIMIT_WIDTH-1:0]      csr_data
);

   localparam int CW = $clog2(CAPACITY + 1);   // count width
   localparam int IW = $clog2(CAPACITY);       // index width

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INSERT = 3'd1;
   localparam logic [2:0] ST_PRUNE  = 3'd2;
   localparam logic [2:0] ST_CUT    = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;

   logic [2:0]                       state_ff, state_in;
   logic [CW-1:0]                    total_ff, total_in;
   logic [CW-1:0]                    idx_ff, idx_in;
   logic [CW-1:0]                    nread_ff, nread_in;
   logic [srlp_pkg::LIMIT_WIDTH-1:0] limit_ff, limit_in;
   logic [srlp_pkg::LIMIT_WIDTH:0]   sum_ff, sum_in;
   logic [63:0]                      bound_ff, bound_in;
   srlp_pkg::rec_type                key_ff, key_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   srlp_pkg::rsp_type                rsp_ff, rsp_in;

   srlp_pkg::cell_ctrl_type ctrl;
   srlp_pkg::rec_type       cell_rec [CAPACITY];
   logic                    cell_gt  [CAPACITY];
   srlp_pkg::rec_type       head_rec;
   srlp_pkg::rec_type       probe_rec;
   logic [srlp_pkg::LIMIT_WIDTH:0] sum_next;

   // Cells at index >= total hold stale data; force them to take the insert.
   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         srlp_pkg::rec_type left_r, right_r;
         logic              left_gt, gt_raw, vacant_r;
         if (g == 0) begin : g_first
            assign left_r  = key_ff;
            assign left_gt = 1'b0;
         end else begin : g_mid
            assign left_r  = cell_rec[g-1];
            assign left_gt = cell_gt[g-1];
         end
         if (g == CAPACITY - 1) begin : g_tail
            assign right_r = cell_rec[g];
         end else begin : g_body
            assign right_r = cell_rec[g+1];
         end
         assign vacant_r = CW'(g) >= total_ff;
         srlp_cell u_cell (
            .clock        (clock),
            .ctrl         (ctrl),
            .new_rec      (key_ff),
            .left_rec     (left_r),
            .left_greater (left_gt),
            .vacant       (vacant_r),
            .right_rec    (right_r),
            .rec          (cell_rec[g]),
            .greater      (gt_raw)
         );
         assign cell_gt[g] = gt_raw || vacant_r;
      end
   endgenerate

   assign head_rec  = cell_rec[0];
   assign probe_rec = cell_rec[idx_ff[IW-1:0]];
   assign sum_next  = sum_ff + (srlp_pkg::LIMIT_WIDTH+1)'(probe_rec.point_count);

   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   function automatic srlp_pkg::rsp_type ack(input logic [CW-1:0] n, input logic ovf);
      srlp_pkg::rsp_type r;
      r             = '0;
      r.kind        = srlp_pkg::KIND_ACK;
      r.list_length = srlp_pkg::LEN_WIDTH'(n);
      r.overflow    = ovf;
      r.last        = 1'b1;
      return r;
   endfunction

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      nread_in     = nread_ff;
      limit_in     = limit_ff;
      sum_in       = sum_ff;
      bound_in     = bound_ff;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctrl         = '0;
      if (csr_valid && csr_ready) begin
         limit_in = csr_data;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_item.operation == srlp_pkg::OP_INSERT) begin
                  if (total_ff >= CW'(CAPACITY)) begin
                     // Drop the record, flag overflow.
                     rsp_valid_in = 1'b1;
                     rsp_in       = ack(total_ff, 1'b1);
                  end else begin
                     key_in   = '{req_item.first_stamp, req_item.last_stamp,
                                  req_item.data_offset, req_item.point_count,
                                  req_item.data_bytes, req_item.compressed};
                     state_in = ST_INSERT;
                  end
               end else if (total_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  rsp_in.kind  = srlp_pkg::KIND_EMPTY;
                  rsp_in.last  = 1'b1;
               end else begin
                  nread_in = total_ff;
                  idx_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_INSERT: begin
            // Shift the tail right and drop the key into its slot.
            ctrl.insert = 1'b1;
            total_in    = total_ff + 1'b1;
            idx_in      = '0;
            sum_in      = '0;
            if (limit_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = ack(total_ff + 1'b1, 1'b0);
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_PRUNE;
            end
         end
         ST_PRUNE: begin
            // Walk from the head summing points until the limit is met or the list ends.
            if (idx_ff >= total_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = ack(total_ff, 1'b0);
               state_in     = ST_IDLE;
            end else begin
               sum_in   = sum_next;
               bound_in = probe_rec.first_stamp;
               idx_in   = idx_ff + 1'b1;
               if (sum_next >= {1'b0, limit_ff}) begin
                  state_in = ST_CUT;
               end
            end
         end
         ST_CUT: begin
            // Advance past entries tied with the bound, then cut the count.
            if (idx_ff >= total_ff || probe_rec.first_stamp > bound_ff) begin
               total_in     = idx_ff;
               rsp_valid_in = 1'b1;
               rsp_in       = ack(idx_ff, 1'b0);
               state_in     = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_READ: begin
            // Emit the head entry and shift the chain toward the head.
            ctrl.shift                 = 1'b1;
            rsp_valid_in               = 1'b1;
            rsp_in.kind                = srlp_pkg::KIND_ENTRY;
            rsp_in.entry_start_time    = head_rec.first_stamp;
            rsp_in.entry_end_time      = head_rec.last_stamp;
            rsp_in.entry_offset        = head_rec.data_offset;
            rsp_in.entry_point_count   = head_rec.point_count;
            rsp_in.entry_length        = head_rec.data_bytes;
            rsp_in.entry_compressed    = head_rec.compressed;
            rsp_in.list_length         = srlp_pkg::LEN_WIDTH'(nread_ff);
            rsp_in.overflow            = 1'b0;
            rsp_in.last                = (idx_ff + 1'b1) == nread_ff;
            idx_in                     = idx_ff + 1'b1;
            if ((idx_ff + 1'b1) == nread_ff) begin
               total_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         nread_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         nread_ff     <= nread_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      bound_ff <= bound_in;
      key_ff   <= key_in;
      rsp_ff   <= rsp_in;
   end

endmodule

// File: hdl/srlp_checker.sv
// Module: port-level checker for the sorted record list, with its bind.
module srlp_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input srlp_pkg::rsp_type rsp_item
);

   // Accepted item always leads to busy or an immediate result.
   a_accept_acts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item produced neither work nor result");

   // No result while idle unless it was just accepted or finished.
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(busy) && !$past(start)) |-> 1'b0)
      else $error("result without a request");

   // Acknowledgements and empty read-outs are always final.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.kind != srlp_pkg::KIND_ENTRY) |-> rsp_item.last)
      else $error("single result not marked last");

   // Overflow only on an acknowledgement.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.overflow) |-> (rsp_item.kind == srlp_pkg::KIND_ACK))
      else $error("overflow on non-acknowledge");

endmodule

bind sorted_record_list_with_limit_prune_top srlp_checker u_srlp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

// File: test/sorted_record_list_with_limit_prune_checker.sv
// Checker: predicts the sorted record table and compares every result item.
`timescale 1ns / 1ps

module sorted_record_list_with_limit_prune_checker #(
   parameter int CAPACITY = srlp_pkg::CAPACITY_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  srlp_pkg::req_type                req_item,
   input  logic                             rsp_valid,
   input  srlp_pkg::rsp_type                rsp_item,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [srlp_pkg::LIMIT_WIDTH-1:0] csr_data,
   output int                               fail_count,
   output int                               results_owed
);

   srlp_pkg::rec_type                table_rec [CAPACITY];
   int                               table_len;
   logic [srlp_pkg::LIMIT_WIDTH-1:0] point_limit;
   srlp_pkg::rsp_type                owed_results [$];

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Keep the prefix up to the last entry sharing the start time at which the limit is met.
   task automatic prune_table();
      logic [63:0] sum;
      logic [63:0] bound;
      bit          reached;
      int          i;
      sum = '0;
      bound = '0;
      reached = 0;
      if (point_limit == '0) return;
      for (i = 0; i < table_len; i++) begin
         sum += table_rec[i].point_count;
         bound = table_rec[i].first_stamp;
         if (sum >= point_limit) begin
            reached = 1;
            break;
         end
      end
      if (!reached) return;
      for (i = 0; i < table_len; i++)
         if (table_rec[i].first_stamp > bound) break;
      table_len = i;
   endtask

   task automatic predict_item(input srlp_pkg::req_type item);
      srlp_pkg::rsp_type r;
      int                pos;
      r = '0;
      r.last = 1'b1;
      if (item.operation == srlp_pkg::OP_INSERT) begin
         r.kind = srlp_pkg::KIND_ACK;
         if (table_len >= CAPACITY) begin
            r.overflow = 1'b1;
         end else begin
            pos = 0;
            while (pos < table_len && table_rec[pos].first_stamp <= item.first_stamp) pos++;
            for (int j = table_len; j > pos; j--) table_rec[j] = table_rec[j-1];
            table_rec[pos] = '{item.first_stamp, item.last_stamp, item.data_offset,
                               item.point_count, item.data_bytes, item.compressed};
            table_len++;
            prune_table();
         end
         r.list_length = srlp_pkg::LEN_WIDTH'(table_len);
         owed_results.push_back(r);
      end else if (table_len == 0) begin
         r.kind = srlp_pkg::KIND_EMPTY;
         owed_results.push_back(r);
      end else begin
         for (int i = 0; i < table_len; i++) begin
            r = '0;
            r.kind              = srlp_pkg::KIND_ENTRY;
            r.entry_start_time  = table_rec[i].first_stamp;
            r.entry_end_time    = table_rec[i].last_stamp;
            r.entry_offset      = table_rec[i].data_offset;
            r.entry_point_count = table_rec[i].point_count;
            r.entry_length      = table_rec[i].data_bytes;
            r.entry_compressed  = table_rec[i].compressed;
            r.list_length       = srlp_pkg::LEN_WIDTH'(table_len);
            r.last              = (i == table_len - 1);
            owed_results.push_back(r);
         end
         table_len = 0;
      end
   endtask

   always @(posedge clock) begin
      srlp_pkg::rsp_type want;
      if (reset) begin
         table_len = 0;
         point_limit = '0;
         fail_count = 0;
         owed_results.delete();
      end else begin
         if (rsp_valid) begin
            if (owed_results.size() == 0) begin
               $error("result item with nothing expected");
               fail_count++;
            end else begin
               want = owed_results.pop_front();
               check_field("kind", want.kind, rsp_item.kind);
               check_field("entry_start_time", want.entry_start_time,
                           rsp_item.entry_start_time);
               check_field("entry_end_time", want.entry_end_time, rsp_item.entry_end_time);
               check_field("entry_offset", want.entry_offset, rsp_item.entry_offset);
               check_field("entry_point_count", want.entry_point_count,
                           rsp_item.entry_point_count);
               check_field("entry_length", want.entry_length, rsp_item.entry_length);
               check_field("entry_compressed", want.entry_compressed,
                           rsp_item.entry_compressed);
               check_field("list_length", want.list_length, rsp_item.list_length);
               check_field("overflow", want.overflow, rsp_item.overflow);
               check_field("last", want.last, rsp_item.last);
            end
         end
         if (csr_valid && csr_ready) point_limit = csr_data;
         if (start && !busy) predict_item(req_item);
      end
      results_owed = owed_results.size();
   end

endmodule

// File: test/sorted_record_list_with_limit_prune_top_tb.sv
// Testbench top: clock, reset, item and limit stimulus, and the final verdict.
`timescale 1ns / 1ps

module sorted_record_list_with_limit_prune_top_tb;

   localparam int CAPACITY = srlp_pkg::CAPACITY_DEFAULT;
   // Longest quiet stretch the block may still be working: full prune walk plus margin.
   localparam int SETTLE_CYCLES = CAPACITY + 8;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   srlp_pkg::req_type                req_item = '0;
   logic                             rsp_valid;
   srlp_pkg::rsp_type                rsp_item;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [srlp_pkg::LIMIT_WIDTH-1:0] csr_data = '0;
   int                               fail_count;
   int                               results_owed;

   always #5 clock = ~clock;

   sorted_record_list_with_limit_prune_top #(.CAPACITY(CAPACITY)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   sorted_record_list_with_limit_prune_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data), .fail_count(fail_count),
      .results_owed(results_owed)
   );

   // Present one item at a falling edge, hold it until taken, then idle a random gap.
   // Called and returning at a falling edge; busy is stable there, so the rising edge
   // after a falling edge with busy low takes the item.
   task automatic issue_item(input srlp_pkg::req_type item);
      req_item = item;
      start = 1'b1;
      while (busy) @(negedge clock);
      @(negedge clock);
      start = 1'b0;
      // Random gap: sometimes back to back, sometimes a longer pause.
      repeat ($urandom_range(0, 14)) @(negedge clock);
   endtask

   function automatic srlp_pkg::req_type make_insert(input logic [63:0] st,
                                                    input logic [15:0] pc);
      srlp_pkg::req_type r;
      r.operation   = srlp_pkg::OP_INSERT;
      r.first_stamp = st;
      r.last_stamp  = {$urandom, $urandom};
      r.data_offset = $urandom;
      r.point_count = pc;
      r.data_bytes  = 16'($urandom_range(0, 65535));
      r.compressed  = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic srlp_pkg::req_type make_readout();
      srlp_pkg::req_type r;
      r = '0;
      r.operation = srlp_pkg::OP_READOUT;
      // Fill the unused fields too; the block must ignore them.
      r.first_stamp = {$urandom, $urandom};
      r.point_count = 16'($urandom_range(0, 65535));
      return r;
   endfunction

   // Drain, let any prune walk finish, then write the limit register.
   task automatic write_limit(input logic [srlp_pkg::LIMIT_WIDTH-1:0] value);
      while (results_owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_data = value;
      csr_valid = 1'b1;
      while (!csr_ready) @(negedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Random start times: a narrow range gives many ties, full width elsewhere.
   function automatic logic [63:0] pick_start();
      case ($urandom_range(0, 3))
         0:       return {$urandom, $urandom};
         1:       return 64'hFFFF_FFFF_FFFF_FFF0 + 64'($urandom_range(0, 15));
         default: return 64'($urandom_range(0, 24));
      endcase
   endfunction

   function automatic logic [15:0] pick_count();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom_range(0, 65535));
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 40));
      endcase
   endfunction

   initial begin
      logic [srlp_pkg::LIMIT_WIDTH-1:0] limits [6];
      int                               readout_odds;
      srlp_pkg::req_type                item;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty read-out, field extremes, ties at both ends of time.
      issue_item(make_readout());
      item = '1;
      item.operation = srlp_pkg::OP_INSERT;
      issue_item(item);
      item = '0;
      issue_item(item);
      issue_item(make_insert('1, 16'h0001));
      issue_item(make_insert('0, 16'h0002));
      issue_item(make_insert(64'd7, 16'hFFFF));
      issue_item(make_readout());
      issue_item(make_readout());

      // Limit of one: the first entry with a nonzero count meets it, ties on its start time stay.
      write_limit(24'd1);
      issue_item(make_insert(64'd10, 16'd0));
      issue_item(make_insert(64'd5, 16'd0));
      issue_item(make_insert(64'd5, 16'd3));
      issue_item(make_insert(64'd5, 16'd1));
      issue_item(make_insert(64'd2, 16'd1));
      issue_item(make_readout());

      // Random phases over several limits, extremes included.
      limits = '{24'd0, 24'hFFFFFF, 24'd60, 24'd1, 24'd0, 24'd0};
      limits[4] = 24'($urandom_range(100, 200000));
      limits[5] = 24'($urandom_range(2, 30));
      for (int p = 0; p < 6; p++) begin
         write_limit(limits[p]);
         // Rare read-outs under a limit that never prunes, so the table fills up.
         readout_odds = (limits[p] == 0 || limits[p] == 24'hFFFFFF) ? 45 : 8;
         for (int n = 0; n < 58; n++) begin
            if ($urandom_range(1, readout_odds) == 1) issue_item(make_readout());
            else issue_item(make_insert(pick_start(), pick_count()));
         end
         issue_item(make_readout());
      end

      while (results_owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("** sorted_record_list_with_limit_prune_top: PASSED **");
      end else begin
         $display("** sorted_record_list_with_limit_prune_top: FAILED **");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("** sorted_record_list_with_limit_prune_top: FAILED **");
      $finish;
   end

endmodule

// File: sorted_record_list_with_limit_prune_top.f
hdl/srlp_pkg.sv
hdl/srlp_cell.sv
hdl/sorted_record_list_with_limit_prune_top.sv
hdl/srlp_checker.sv
test/sorted_record_list_with_limit_prune_checker.sv
test/sorted_record_list_with_limit_prune_top_tb.sv
